// ===== design/lsd_pkg.sv =====
`default_nettype none

package lsd_pkg;

    // default stack depth
    localparam int DEPTH_DEF = 16;

    // request codes
    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] value;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_value;
        logic [4:0]         entry_count;
        logic signed [31:0] top_value;
    } result_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_PUSH,
        DP_POP,
        DP_SRCH_INIT,
        DP_READ_IDX,
        DP_IDX_DEC,
        DP_HIT,
        DP_READ_NEXT,
        DP_SHIFT_WR,
        DP_REMOVE,
        DP_TOP_RD,
        DP_TOP_LOAD,
        DP_TOP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    // datapath conditions seen by the controller
    typedef struct packed {
        logic empty;
        logic full;
        logic match;
        logic idx_zero;
        logic shift_more;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/lsd_dp.sv =====
`default_nettype none

module lsd_dp
    import lsd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire request_t request,
    input  wire dp_cmd_t  cmd,
    output      dp_stat_t stat,
    output logic signed [31:0] out_value,
    output logic [4:0]         entry_count,
    output logic signed [31:0] top_value
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rdata_reg;
    logic [31:0]   val_reg;
    logic [31:0]   taken_reg;
    logic [31:0]   top_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] idx_reg;

    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] idx_ext;
    logic [CW-1:0] idx_p1;
    logic [CW+4:0] cnt_wide;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    assign cnt_m1  = cnt_reg - 1'b1;
    assign idx_ext = CW'(idx_reg);
    assign idx_p1  = idx_ext + 1'b1;

    // conditions
    assign stat.empty      = (cnt_reg == '0);
    assign stat.full       = (cnt_reg == CW'(DEPTH));
    assign stat.match      = (rdata_reg == val_reg);
    assign stat.idx_zero   = (idx_reg == '0);
    assign stat.shift_more = (idx_p1 < cnt_reg);

    // memory port selection
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = rdata_reg;
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        unique case (cmd.op)
            DP_PUSH:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[AW-1:0];
                wr_data = val_reg;
            end
            DP_SHIFT_WR: wr_en = 1'b1;
            DP_READ_IDX: rd_en = 1'b1;
            DP_READ_NEXT:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_p1[AW-1:0];
            end
            DP_TOP_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = cnt_m1[AW-1:0];
            end
            default: ;
        endcase
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_CAPTURE:
            begin
                val_reg   <= request.value;
                taken_reg <= '0;
            end
            DP_POP:       taken_reg <= top_reg;
            DP_HIT:       taken_reg <= val_reg;
            DP_SRCH_INIT: idx_reg   <= cnt_m1[AW-1:0];
            DP_IDX_DEC:   idx_reg   <= idx_reg - 1'b1;
            DP_SHIFT_WR:  idx_reg   <= idx_p1[AW-1:0];
            default: ;
        endcase
    end

    // count and top value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            top_reg <= '0;
        end
        else
        begin
            unique case (cmd.op)
                DP_PUSH:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    top_reg <= val_reg;
                end
                DP_POP:       cnt_reg <= cnt_m1;
                DP_REMOVE:    cnt_reg <= cnt_m1;
                DP_TOP_LOAD:  top_reg <= rdata_reg;
                DP_TOP_CLEAR: top_reg <= '0;
                default: ;
            endcase
        end
    end

    assign cnt_wide    = {5'b0, cnt_reg};
    assign entry_count = cnt_wide[4:0];
    assign out_value   = taken_reg;
    assign top_value   = top_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_PUSH) |-> !stat.full)
        else $error("write on a full stack");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_READ_NEXT) |-> (stat.shift_more && !stat.empty))
        else $error("shift read beyond top");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_REMOVE) |=> (cnt_reg == $past(cnt_m1)))
        else $error("remove did not drop the count");

endmodule

`default_nettype wire

// ===== design/lsd_ctrl.sv =====
`default_nettype none

module lsd_ctrl
    import lsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] req_type,
    input  wire dp_stat_t   stat,
    output      dp_cmd_t    cmd,
    output logic            busy,
    output logic            done,
    output logic [1:0]      status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_RM_INIT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_TOP_RD,
        S_TOP_LD
    } state_t;

    state_t     state_reg, state_next;
    logic       done_reg, done_next;
    logic [1:0] status_reg, status_next;

    // next state and datapath command
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        cmd.op      = DP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = DP_CAPTURE;
                    unique case (req_type)
                        REQ_PUSH:   state_next = S_PUSH;
                        REQ_POP:    state_next = S_POP;
                        REQ_REMOVE: state_next = S_RM_INIT;
                        default:
                        begin
                            // unused code: report the stack as it is
                            done_next   = 1'b1;
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (stat.full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.op      = DP_PUSH;
                    status_next = ST_DONE;
                end
            end
            S_POP:
            begin
                if (stat.empty)
                begin
                    done_next   = 1'b1;
                    status_next = ST_EMPTY;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.op     = DP_POP;
                    state_next = S_TOP_RD;
                end
            end
            S_RM_INIT:
            begin
                if (stat.empty)
                begin
                    done_next   = 1'b1;
                    status_next = ST_EMPTY;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.op     = DP_SRCH_INIT;
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                cmd.op     = DP_READ_IDX;
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                // walk from top toward bottom
                if (stat.match)
                begin
                    cmd.op     = DP_HIT;
                    state_next = S_SHIFT_RD;
                end
                else if (stat.idx_zero)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.op     = DP_IDX_DEC;
                    state_next = S_SRCH_RD;
                end
            end
            S_SHIFT_RD:
            begin
                // close the gap one entry at a time
                if (stat.shift_more)
                begin
                    cmd.op     = DP_READ_NEXT;
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    cmd.op     = DP_REMOVE;
                    state_next = S_TOP_RD;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.op     = DP_SHIFT_WR;
                state_next = S_SHIFT_RD;
            end
            S_TOP_RD:
            begin
                if (stat.empty)
                begin
                    cmd.op      = DP_TOP_CLEAR;
                    done_next   = 1'b1;
                    status_next = ST_DONE;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.op     = DP_TOP_RD;
                    state_next = S_TOP_LD;
                end
            end
            S_TOP_LD:
            begin
                cmd.op      = DP_TOP_LOAD;
                done_next   = 1'b1;
                status_next = ST_DONE;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            status_reg <= ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

    // checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle");

    a_push_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) |=> (done_reg && state_reg == S_IDLE))
        else $error("push did not finish in one step");

    a_shift_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_WR) |-> ($past(state_reg) == S_SHIFT_RD))
        else $error("shift write without read");

endmodule

`default_nettype wire

// ===== design/lifo_stack_with_delete.sv =====
`default_nettype none

// Channel  Signals                    Transfer
// -------  -------------------------  -------------------------------------
// request  start, busy, request       taken at clk edge with start && !busy
// result   done, result               valid one cycle while done is high
//
// A push or a refused push passes through the push state to the done
// strobe, an unused code strobes done straight from idle. A pop adds one
// read of the entry memory for the new top. Remove searches from the top
// down, one entry at a time through the single read port, then shifts the
// entries above the hit down to close the gap, then reads the new top.
// Reset clears the count, top and controller; entries need no clearing.
// The receiver cannot stall; busy is low again in the strobe cycle.

module lifo_stack_with_delete
    import lsd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output      logic     busy,
    input  wire request_t request,
    output      logic     done,
    output      result_t  result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done),
        .status   (result.status)
    );

    lsd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .cmd         (cmd),
        .stat        (stat),
        .out_value   (result.out_value),
        .entry_count (result.entry_count),
        .top_value   (result.top_value)
    );

endmodule

`default_nettype wire
